// File: rtl/core/evwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package evwm_pkg;

    localparam int unsigned AddrWidth = 4;
    localparam int unsigned DataWidth = 32;

    localparam logic [1:0] RegSpinHoldoff  = 2'd0;
    localparam logic [1:0] RegPressHoldoff = 2'd1;
    localparam logic [1:0] RegMaxVolume    = 2'd2;

    localparam logic [31:0] SpinHoldoffRst  = 32'd17;
    localparam logic [31:0] PressHoldoffRst = 32'd50;
    localparam logic [7:0]  MaxVolumeRst    = 8'd16;
    localparam logic [7:0]  LevelRst        = 8'd8;
    localparam logic [8:0]  NoReport        = 9'h1FF;

    typedef struct packed {
        logic        clk_level;
        logic        dt_level;
        logic        button_level;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [7:0] volume;
        logic       volume_changed;
        logic       muted;
    } t_out;

    typedef struct packed {
        logic [31:0] spin_holdoff_ms;
        logic [31:0] press_holdoff_ms;
        logic [7:0]  max_volume;
    } t_cfg;

endpackage

`default_nettype wire

// File: rtl/core/evwm_knob.sv
`timescale 1ns / 1ps
`default_nettype none

module evwm_knob (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire evwm_pkg::t_in  i_item,
    input  wire evwm_pkg::t_cfg i_cfg,
    output evwm_pkg::t_out      o_result
);
    import evwm_pkg::*;

    logic        r_prev_clk;
    logic        r_prev_button;
    logic [7:0]  r_level;
    logic [7:0]  r_saved_level;
    logic        r_mute_on;
    logic [31:0] r_last_turn_time;
    logic [31:0] r_last_press_time;
    logic [8:0]  r_reported_level;

    logic [31:0] turn_gap;
    logic [31:0] press_gap;
    logic        turn;
    logic        press;
    logic [7:0]  lvl_turn;
    logic [7:0]  n_level;
    logic [7:0]  n_saved_level;
    logic        n_mute_on;
    logic        changed;

    assign turn_gap  = i_item.now_ms - r_last_turn_time;
    assign press_gap = i_item.now_ms - r_last_press_time;
    assign turn  = (turn_gap > i_cfg.spin_holdoff_ms) && r_prev_clk && !i_item.clk_level;
    assign press = (press_gap > i_cfg.press_holdoff_ms) && r_prev_button
                   && !i_item.button_level;

    always_comb begin
        lvl_turn = r_level;
        if (turn) begin
            if (!i_item.dt_level) begin
                if (r_level < i_cfg.max_volume) lvl_turn = r_level + 8'd1;
            end else begin
                if (r_level != 8'd0) lvl_turn = r_level - 8'd1;
            end
        end
        n_level       = lvl_turn;
        n_saved_level = r_saved_level;
        n_mute_on     = r_mute_on;
        if (press) begin
            if (!r_mute_on) begin
                n_mute_on     = 1'b1;
                n_saved_level = lvl_turn;
                n_level       = 8'd0;
            end else begin
                n_mute_on = 1'b0;
                n_level   = r_saved_level;
            end
        end
    end

    assign changed = ({1'b0, n_level} != r_reported_level);

    assign o_result.volume         = n_level;
    assign o_result.volume_changed = changed;
    assign o_result.muted          = n_mute_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_clk        <= 1'b1;
            r_prev_button     <= 1'b1;
            r_level           <= LevelRst;
            r_saved_level     <= LevelRst;
            r_mute_on         <= 1'b0;
            r_last_turn_time  <= '0;
            r_last_press_time <= '0;
            r_reported_level  <= NoReport;
        end else if (i_fire) begin
            r_prev_clk    <= i_item.clk_level;
            r_prev_button <= i_item.button_level;
            r_level       <= n_level;
            r_saved_level <= n_saved_level;
            r_mute_on     <= n_mute_on;
            if (turn) r_last_turn_time <= i_item.now_ms;
            if (press) r_last_press_time <= i_item.now_ms;
            if (changed) r_reported_level <= {1'b0, n_level};
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/encoder_volume_with_mute_core.sv
// Rotary encoder volume knob with mute.
// Input channel: one item per pin sample (clk, dt, button levels and a
// millisecond tick), accepted when i_in_valid is high and o_in_stall low.
// Output channel: one item per input item (volume, changed flag, mute
// state), taken when o_out_valid is high and i_out_stall low.
// Path: an accepted item is held in the input register, then makes one pass
// through the compare/increment logic into the result register.
// Throughput: one item per cycle unless the receiver stalls; the knob state
// is updated in that same pass, so each item sees the state left by the item
// before it. When the receiver stalls, the result holds; one more item waits
// in the input register, after which o_in_stall rises until the result is taken.
// Reset (synchronous, active low) restores the hold-off times (17 ms and
// 50 ms), the volume limit (16), volume 8, unmuted, and clears both
// valid flags; the first item after reset always reports a change.
// Registers via APB: 0x0 spin hold-off, 0x4 press hold-off, 0x8 limit.
// Write them only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module encoder_volume_with_mute_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire evwm_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output evwm_pkg::t_out                       o_out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [evwm_pkg::AddrWidth-1:0]  paddr,
    input  wire logic [evwm_pkg::DataWidth-1:0]  pwdata,
    output logic      [evwm_pkg::DataWidth-1:0]  prdata,
    output logic                                 pready
);
    import evwm_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    t_in        r_in;
    logic       r_out_valid;
    t_out       r_out;
    t_out       result;
    logic       advance;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_comb begin
        unique case (reg_idx)
            RegSpinHoldoff:  prdata = r_cfg.spin_holdoff_ms;
            RegPressHoldoff: prdata = r_cfg.press_holdoff_ms;
            RegMaxVolume:    prdata = {24'd0, r_cfg.max_volume};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spin_holdoff_ms  <= SpinHoldoffRst;
            r_cfg.press_holdoff_ms <= PressHoldoffRst;
            r_cfg.max_volume       <= MaxVolumeRst;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                RegSpinHoldoff:  r_cfg.spin_holdoff_ms  <= pwdata;
                RegPressHoldoff: r_cfg.press_holdoff_ms <= pwdata;
                RegMaxVolume:    r_cfg.max_volume       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) r_in <= i_in_data;
    end

    evwm_knob u_knob (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_out <= result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import evwm_pkg::*;

    localparam logic [1:0] RegUnused = 2'd3;
    localparam int NumPhases  = 8;
    localparam int PhaseItems = 225;
    localparam int HoldCycles = 400;
    localparam int IdleLimit  = 3000;

    class knob_scoreboard;
        logic [31:0] spin_hold;
        logic [31:0] press_hold;
        logic [7:0]  vol_limit;
        logic        prev_clk;
        logic        prev_btn;
        logic        mute_on;
        logic [7:0]  level;
        logic [7:0]  saved_level;
        logic [31:0] last_turn;
        logic [31:0] last_press;
        logic [8:0]  reported;
        t_out        reports_due[$];
        int          errors;

        function new();
            spin_hold   = SpinHoldoffRst;
            press_hold  = PressHoldoffRst;
            vol_limit   = MaxVolumeRst;
            prev_clk    = 1'b1;
            prev_btn    = 1'b1;
            mute_on     = 1'b0;
            level       = LevelRst;
            saved_level = LevelRst;
            last_turn   = '0;
            last_press  = '0;
            reported    = NoReport;
            errors      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                RegSpinHoldoff:  spin_hold  = val;
                RegPressHoldoff: press_hold = val;
                RegMaxVolume:    vol_limit  = val[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return reports_due.size();
        endfunction

        function void note_sample(t_in s);
            t_out e;
            logic [31:0] since;
            since = s.now_ms - last_turn;
            if (since > spin_hold && prev_clk && !s.clk_level) begin
                if (!s.dt_level) begin
                    if (level < vol_limit) level = level + 8'd1;
                end else if (level != 8'd0) begin
                    level = level - 8'd1;
                end
                last_turn = s.now_ms;
            end
            since = s.now_ms - last_press;
            if (since > press_hold && prev_btn && !s.button_level) begin
                if (!mute_on) begin
                    mute_on     = 1'b1;
                    saved_level = level;
                    level       = 8'd0;
                end else begin
                    mute_on = 1'b0;
                    level   = saved_level;
                end
                last_press = s.now_ms;
            end
            e.volume         = level;
            e.volume_changed = ({1'b0, level} != reported);
            e.muted          = mute_on;
            if (e.volume_changed) reported = {1'b0, level};
            prev_clk = s.clk_level;
            prev_btn = s.button_level;
            reports_due.push_back(e);
        endfunction

        function void check_result(t_out r);
            t_out e;
            if (reports_due.size() == 0) begin
                $error("result with no item pending: volume %0d", r.volume);
                errors++;
                return;
            end
            e = reports_due.pop_front();
            if (r.volume !== e.volume) begin
                $error("volume: expected %0d, got %0d", e.volume, r.volume);
                errors++;
            end
            if (r.volume_changed !== e.volume_changed) begin
                $error("volume_changed: expected %0b, got %0b",
                       e.volume_changed, r.volume_changed);
                errors++;
            end
            if (r.muted !== e.muted) begin
                $error("muted: expected %0b, got %0b", e.muted, r.muted);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AddrWidth-1:0] paddr;
    logic [DataWidth-1:0] pwdata;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    knob_scoreboard sb = new();

    bit          in_idle  = 1'b1;
    bit          out_idle = 1'b1;
    bit          hold_req = 1'b0;
    logic [31:0] tick     = '0;
    logic        dir      = 1'b0;
    int          step_max = 40;
    int          idle_count = 0;

    encoder_volume_with_mute_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_in mk(logic c, logic d, logic b, logic [31:0] t);
        t_in s;
        s.clk_level    = c;
        s.dt_level     = d;
        s.button_level = b;
        s.now_ms       = t;
        return s;
    endfunction

    function automatic t_in next_sample();
        t_in s;
        if ($urandom_range(0, 99) < 3) tick = $urandom;
        else tick = tick + $urandom_range(0, step_max);
        if ($urandom_range(0, 39) == 0) dir = ~dir;
        s.clk_level    = $urandom_range(0, 1);
        s.dt_level     = ($urandom_range(0, 9) < 8) ? dir : ~dir;
        s.button_level = ($urandom_range(0, 7) != 0);
        s.now_ms       = tick;
        return s;
    endfunction

    // caller sits just after a falling edge; returns the same way
    task automatic send_item(t_in s);
        int gap;
        gap = in_idle ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = s;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(s);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            idle_count <= 0;
        end else if (idle_count + 1 >= IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    initial begin : receiver
        int w;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HoldCycles) @(negedge i_clk);
                hold_req    = 1'b0;
                i_out_stall = 1'b0;
            end
            w = out_idle ? $urandom_range(0, 16) : 0;
            if (w != 0) begin
                i_out_stall = 1'b1;
                repeat (w) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings: hold-offs 17/50, limit 16
        send_item(mk(1, 0, 1, 32'd0));
        send_item(mk(0, 0, 1, 32'd100));
        send_item(mk(1, 0, 1, 32'd105));
        send_item(mk(0, 1, 1, 32'd110));          // inside spin hold-off
        send_item(mk(1, 1, 1, 32'd130));
        send_item(mk(0, 1, 1, 32'd140));
        send_item(mk(1, 1, 0, 32'd300));          // mute
        send_item(mk(1, 1, 1, 32'd310));
        send_item(mk(1, 1, 0, 32'd320));          // inside press hold-off
        send_item(mk(0, 0, 1, 32'd400));          // turn while muted
        send_item(mk(1, 0, 0, 32'd500));          // unmute restores
        send_item(mk(1, 0, 1, 32'd600));
        send_item(mk(0, 0, 0, 32'd700));          // turn and press together
        send_item(mk(1, 0, 1, 32'd800));
        send_item(mk(0, 1, 1, 32'hFFFF_FFF0));
        send_item(mk(1, 1, 0, 32'hFFFF_FFFF));
        send_item(mk(0, 1, 1, 32'd5));            // tick wrapped
        drain();
        write_reg(RegMaxVolume, 32'd4);           // volume now above limit
        send_item(mk(1, 0, 1, 32'd100));
        send_item(mk(0, 0, 1, 32'd200));
        send_item(mk(1, 1, 1, 32'd300));
        send_item(mk(0, 1, 1, 32'd400));
        drain();
        write_reg(RegMaxVolume, 32'd0);
        write_reg(RegUnused, 32'hFFFF_FFFF);
        send_item(mk(1, 0, 1, 32'd500));
        send_item(mk(0, 0, 1, 32'd600));
        tick = 32'd600;

        for (int ph = 0; ph < NumPhases; ph++) begin
            drain();
            in_idle  = (ph % 3) != 1;
            out_idle = (ph % 3) != 2;
            step_max = 40;
            case (ph)
                0: begin
                    write_reg(RegSpinHoldoff, 32'd0);
                    write_reg(RegPressHoldoff, 32'd0);
                    write_reg(RegMaxVolume, 32'd255);
                    step_max = 3;
                end
                1: begin
                    write_reg(RegSpinHoldoff, 32'hFFFF_FFFF);
                    write_reg(RegPressHoldoff, 32'hFFFF_FFFF);
                    write_reg(RegMaxVolume, 32'd1);
                end
                4: begin
                    write_reg(RegSpinHoldoff, $urandom_range(0, 30));
                    write_reg(RegPressHoldoff, $urandom_range(0, 80));
                    write_reg(RegMaxVolume, $urandom_range(1, 20));
                    in_idle  = 1'b0;
                    hold_req = 1'b1;
                end
                5: begin
                    write_reg(RegSpinHoldoff, 32'd5);
                    write_reg(RegPressHoldoff, 32'd20);
                    write_reg(RegMaxVolume, 32'd0);
                end
                6: begin
                    write_reg(RegSpinHoldoff, $urandom);
                    write_reg(RegPressHoldoff, $urandom);
                    write_reg(RegMaxVolume, $urandom_range(1, 255));
                end
                default: begin
                    write_reg(RegSpinHoldoff, $urandom_range(0, 30));
                    write_reg(RegPressHoldoff, $urandom_range(0, 80));
                    write_reg(RegMaxVolume, $urandom_range(1, 20));
                end
            endcase
            for (int n = 0; n < PhaseItems; n++) send_item(next_sample());
        end

        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
